// ----- hw/rtl/art_pkg.sv -----
// ----------------------------------------------------------------------------
// art_pkg
// Shared widths, defaults, status codes and request modes of the address resolution table.
// ----------------------------------------------------------------------------
package art_pkg;

   localparam int ENTRIES_DEFAULT = 32;

   localparam int NET_W    = 32;
   localparam int HW_W     = 48;
   localparam int STATUS_W = 3;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_PRESENT  = 3'd1,
      ST_FULL     = 3'd2,
      ST_FOUND    = 3'd3,
      ST_MISSING  = 3'd4
   } status_type;

   typedef enum logic {
      MODE_UPDATE = 1'b0,
      MODE_LOOKUP = 1'b1
   } mode_type;

endpackage

// ----- hw/rtl/address_resolution_table.sv -----
// ----------------------------------------------------------------------------
// address_resolution_table
// Append-only table mapping a network address to a hardware address.
// ----------------------------------------------------------------------------
// Usage
//  req_*  : one transaction per operation. req_mode selects update (append a
//           pair unless present or full) or lookup (first matching slot wins,
//           a non-matching slot holding address zero ends the scan as a miss).
//  rsp_*  : exactly one result transaction per request, in order.
//  Timing : a request is scanned one slot per cycle out of two synchronous
//           RAMs (registered read, read and compare overlapped). The
//           result is registered once the scan ends; a new request is
//           taken only after the result of the last one is registered.
//           A full-table update answers without reading any slot.
//  Reset  : clears the fill count and control state. Slots at or beyond the
//           fill count are treated as holding zeros, so no clearing pass is
//           run and the block takes a request straight after reset.
//  Stall  : the result sits in an output register; a new request is taken
//           while it waits. A finished scan holds (no more reads) until the
//           output register is free.
// ----------------------------------------------------------------------------
module address_resolution_table
   import art_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic [NET_W-1:0]    req_net_addr,
   input  logic [HW_W-1:0]     req_hw_addr_in,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [HW_W-1:0]     rsp_hw_addr_out,
   output logic [NET_W-1:0]    rsp_found_addr
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   // control
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;   // next slot to read
   logic               chk_vld_ff, chk_vld_in; // RAM output holds a slot to check

   // captured request
   logic               mode_ff, mode_in;
   logic [NET_W-1:0]   na_ff, na_in;
   logic [HW_W-1:0]    hw_ff, hw_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [HW_W-1:0]    rsp_hw_ff, rsp_hw_in;
   logic [NET_W-1:0]   rsp_na_ff, rsp_na_in;

   // storage
   logic [NET_W-1:0]   addr_mem [ENTRIES];
   logic [HW_W-1:0]    hw_mem   [ENTRIES];
   logic [NET_W-1:0]   addr_rd_ff;
   logic [HW_W-1:0]    hw_rd_ff;

   logic accept, out_free;
   logic full_upd, hit, zero_stop, end_scan, done, commit;
   logic rd_en, mem_we;
   status_type  res_status;
   logic [HW_W-1:0]  res_hw;
   logic [NET_W-1:0] res_na;

   assign req_ready       = (state_ff == S_IDLE);
   assign accept          = req_valid && req_ready;
   assign out_free        = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_hw_addr_out = rsp_hw_ff;
   assign rsp_found_addr  = rsp_na_ff;

   // Scan decisions. A hit takes priority over the zero-address stop, so a
   // lookup of address zero hits the first zero slot.
   assign full_upd  = (mode_ff == MODE_UPDATE) && (fill_ff == FULL_CNT);
   assign hit       = chk_vld_ff && (addr_rd_ff == na_ff);
   assign zero_stop = chk_vld_ff && (mode_ff == MODE_LOOKUP) && (addr_rd_ff == '0);
   assign end_scan  = (rd_idx_ff == fill_ff);
   assign done      = full_upd || hit || zero_stop || end_scan;
   assign commit    = (state_ff == S_SCAN) && done && out_free;
   assign rd_en     = (state_ff == S_SCAN) && !done;
   assign mem_we    = commit && !full_upd && !hit && !zero_stop
                      && (mode_ff == MODE_UPDATE);

   always_comb begin
      res_status = ST_MISSING;
      res_hw     = '0;
      res_na     = '0;
      if (full_upd) begin
         res_status = ST_FULL;
      end else if (hit) begin
         if (mode_ff == MODE_LOOKUP) begin
            res_status = ST_FOUND;
            res_hw     = hw_rd_ff;
            res_na     = na_ff;
         end else begin
            res_status = ST_PRESENT;
         end
      end else if (zero_stop) begin
         res_status = ST_MISSING;
      end else if (mode_ff == MODE_UPDATE) begin
         res_status = ST_INSERTED;
      end else if ((fill_ff != FULL_CNT) && (na_ff == '0)) begin
         // first unfilled slot reads as zero: hit with a zero hardware address
         res_status = ST_FOUND;
      end
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      rd_idx_in     = rd_idx_ff;
      chk_vld_in    = chk_vld_ff;
      mode_in       = mode_ff;
      na_in         = na_ff;
      hw_in         = hw_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_hw_in     = rsp_hw_ff;
      rsp_na_in     = rsp_na_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in   = S_SCAN;
               mode_in    = req_mode;
               na_in      = req_net_addr;
               hw_in      = req_hw_addr_in;
               rd_idx_in  = '0;
               chk_vld_in = 1'b0;
            end
         end
         S_SCAN: begin
            if (rd_en) begin
               rd_idx_in  = rd_idx_ff + 1'b1;
               chk_vld_in = 1'b1;
            end else if (commit) begin
               state_in      = S_IDLE;
               chk_vld_in    = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status;
               rsp_hw_in     = res_hw;
               rsp_na_in     = res_na;
               if (mem_we) begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      state_ff      <= state_in;
      fill_ff       <= fill_in;
      rd_idx_ff     <= rd_idx_in;
      chk_vld_ff    <= chk_vld_in;
      mode_ff       <= mode_in;
      na_ff         <= na_in;
      hw_ff         <= hw_in;
      rsp_valid_ff  <= rsp_valid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hw_ff     <= rsp_hw_in;
      rsp_na_ff     <= rsp_na_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rd_idx_ff    <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end
   end

   // Slot RAMs: one write port (append at the fill count), one registered
   // read port driven by the scan index. Only the appending write follows a
   // finished scan, so no read can meet a pending write to the same slot.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         addr_mem[fill_ff[IDX_W-1:0]] <= na_ff;
      end
      if (rd_en) begin
         addr_rd_ff <= addr_mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hw_mem[fill_ff[IDX_W-1:0]] <= hw_ff;
      end
      if (rd_en) begin
         hw_rd_ff <= hw_mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_CNT)
      else $error("fill count beyond table depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (rd_idx_ff <= fill_ff))
      else $error("scan index ran past filled slots");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (fill_ff != $past(fill_ff))) |->
         ((fill_ff == $past(fill_ff) + 1'b1) && rsp_valid_ff
          && (rsp_status_ff == ST_INSERTED)))
      else $error("fill count moved without an insert result");

   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_FOUND)) |->
         ((rsp_hw_ff == '0) && (rsp_na_ff == '0)))
      else $error("non-hit result carries address data");

   // read register may still be unwritten before the first slot read
   a_hold_scan: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) && done && !out_free) |=>
         ((state_ff == S_SCAN) && $stable(rd_idx_ff)
          && (addr_rd_ff === $past(addr_rd_ff))))
      else $error("scan advanced while result register was busy");

endmodule
